>>> hw/rtl/pidir_pkg.sv
// ----------------------------------------------------------------------------
// pidir_pkg
// Shared constants for the PID controller with integral reset: field widths,
// command codes, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package pidir_pkg;

	localparam int DATA_W    = 16;   // setpoint, measured, gains, zero band
	localparam int ERR_W     = 17;   // error, setpoint minus measured
	localparam int DRIVE_W   = 32;
	localparam int CMD_W     = 2;
	localparam int CFG_IDX_W = 2;

	localparam int FRAC_BITS_DEF      = 8;
	localparam int INTEGRAL_WIDTH_DEF = 24;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ERROR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DIFF  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_BAND = 2'd3;

endpackage

>>> hw/rtl/pid_controller_integral_reset_top.sv
// ----------------------------------------------------------------------------
// pid_controller_integral_reset_top
// Q8.8 PID step with saturating integral, integral clear on error sign change
// or small error (error command only), and a state reset command.
//
// Channel   Dir  Fields (low bit first)                       Handshake
// s_axis    in   tuser: cmd[1:0]                               tvalid/tready
//                tdata: setpoint[15:0], measured[31:16]
// m_axis    out  tdata: drive[31:0]; tuser: saturated[0]       tvalid/tready
// cfg       in   cfg_index selects gain_p/gain_i/gain_d/zero_band  cfg_we
//
// One item per cycle sustained while the output is not stalled; an item
// passes the input reg, error/integral stage, multiply stage, and sum and
// saturate into the output reg. The integral and last error update as an
// item leaves the input register, which sets the one-item rate.
// Reset clears valids, state and config registers (zero_band to one half).
// Each stage holds while the next is full and stalled; bubbles collapse.
// ----------------------------------------------------------------------------
module pid_controller_integral_reset_top
	import pidir_pkg::*;
#(
	parameter int FRAC_BITS      = FRAC_BITS_DEF,
	parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	// input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,   // setpoint[15:0], measured[31:16]
	input  logic [CMD_W-1:0]     s_axis_tuser,   // cmd[1:0]
	// output stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [DRIVE_W-1:0]   m_axis_tdata,   // drive[31:0]
	output logic                 m_axis_tuser    // saturated[0]
);

	localparam int IW    = INTEGRAL_WIDTH;
	localparam int PI_W  = DATA_W + IW;
	localparam int PP_W  = DATA_W + ERR_W;
	localparam int PD_W  = DATA_W + ERR_W + 1;
	localparam int ACC_W = IW + 18;
	localparam logic [DATA_W-1:0] ZERO_BAND_RST = DATA_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [IW-1:0] INT_MAX = {1'b0, {(IW-1){1'b1}}};
	localparam logic signed [IW-1:0] INT_MIN = {1'b1, {(IW-1){1'b0}}};

	// configuration registers
	logic signed [DATA_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [DATA_W-1:0]        zero_band_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			zero_band_q <= ZERO_BAND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:    gain_p_q    <= cfg_data;
				REG_GAIN_I:    gain_i_q    <= cfg_data;
				REG_GAIN_D:    gain_d_q    <= cfg_data;
				REG_ZERO_BAND: zero_band_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline valids and ready chain
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3, rdy_o;

	assign rdy_o         = !m_axis_tvalid || m_axis_tready;
	assign rdy3          = !v_s3 || rdy_o;
	assign rdy2          = !v_s2 || rdy3;
	assign rdy1          = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	// stage 1: input register
	logic [CMD_W-1:0]         cmd_s1;
	logic signed [DATA_W-1:0] sp_s1, ms_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && rdy1) begin
			cmd_s1 <= s_axis_tuser;
			sp_s1  <= s_axis_tdata[15:0];
			ms_s1  <= s_axis_tdata[31:16];
		end
	end

	// controller state
	logic signed [IW-1:0]    integral_q;
	logic signed [ERR_W-1:0] last_error_q;
	logic                    started_q;

	// error, derivative and integral update
	logic signed [ERR_W-1:0] err, prev;
	logic signed [ERR_W:0]   deriv;
	logic signed [IW:0]      isum;
	logic signed [IW-1:0]    isat_val;
	logic                    isat, is_reset, sign_diff, clr;
	logic [ERR_W-1:0]        mag;

	always_comb begin
		is_reset = 1'b0;
		case (cmd_s1)
			CMD_ERROR: err = {sp_s1[DATA_W-1], sp_s1};
			CMD_DIFF:  err = {sp_s1[DATA_W-1], sp_s1} - {ms_s1[DATA_W-1], ms_s1};
			default: begin
				err      = '0;
				is_reset = 1'b1;
			end
		endcase
		prev  = started_q ? last_error_q : err;
		deriv = {err[ERR_W-1], err} - {prev[ERR_W-1], prev};
		isum  = {integral_q[IW-1], integral_q} + (IW+1)'(err);
		isat  = isum[IW] != isum[IW-1];
		if (isat)
			isat_val = isum[IW] ? INT_MIN : INT_MAX;
		else
			isat_val = isum[IW-1:0];
		mag       = err[ERR_W-1] ? ERR_W'(-err) : err;
		sign_diff = ((err == '0) != (prev == '0)) || (err[ERR_W-1] != prev[ERR_W-1]);
		clr       = (cmd_s1 == CMD_ERROR) && (sign_diff || (mag < {1'b0, zero_band_q}));
	end

	wire adv1 = v_s1 && rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			last_error_q <= '0;
			started_q    <= 1'b0;
		end else if (adv1) begin
			if (is_reset) begin
				integral_q   <= '0;
				last_error_q <= '0;
				started_q    <= 1'b0;
			end else begin
				integral_q   <= clr ? '0 : isat_val;
				last_error_q <= err;
				started_q    <= 1'b1;
			end
		end
	end

	// stage 2: operands for the multipliers (all zero on a reset command)
	logic signed [ERR_W-1:0] e_s2;
	logic signed [IW-1:0]    integ_s2;
	logic signed [ERR_W:0]   d_s2;
	logic                    isat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			e_s2     <= err;
			integ_s2 <= is_reset ? '0 : isat_val;
			d_s2     <= is_reset ? '0 : deriv;
			isat_s2  <= !is_reset && isat;
		end
	end

	// stage 3: products
	logic signed [PP_W-1:0] pp_s3;
	logic signed [PI_W-1:0] pi_s3;
	logic signed [PD_W-1:0] pd_s3;
	logic                   isat_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			pp_s3   <= gain_p_q * e_s2;
			pi_s3   <= gain_i_q * integ_s2;
			pd_s3   <= gain_d_q * d_s2;
			isat_s3 <= isat_s2;
		end
	end

	// sum, floor shift and clamp to 32 bits
	logic signed [ACC_W-1:0]   acc, shifted;
	logic [ACC_W-1:DRIVE_W-1]  upper;
	logic                      osat;
	logic [DRIVE_W-1:0]        drive;

	always_comb begin
		acc     = ACC_W'(pp_s3) + ACC_W'(pi_s3) + ACC_W'(pd_s3);
		shifted = acc >>> FRAC_BITS;
		upper   = shifted[ACC_W-1:DRIVE_W-1];
		osat    = !((&upper) || !(|upper));
		if (osat)
			drive = shifted[ACC_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
			                         : {1'b0, {(DRIVE_W-1){1'b1}}};
		else
			drive = shifted[DRIVE_W-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (rdy_o) begin
			m_axis_tvalid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_o) begin
			m_axis_tdata <= drive;
			m_axis_tuser <= osat || isat_s3;
		end
	end

	// checks
	a_reset_cmd_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 && is_reset |=> !started_q && integral_q == '0 && last_error_q == '0)
		else $error("reset command did not clear controller state");

	a_idle_last_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!started_q |-> last_error_q == '0)
		else $error("last error nonzero before first control step");

	a_empty_out_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output register empty");

endmodule

>>> bench/tb_pid_controller_integral_reset_top.sv
// ----------------------------------------------------------------------------
// tb_pid_controller_integral_reset_top
// Self-checking bench for the Q8.8 PID step with integral clear. A driver
// streams command samples in bursts, a monitor predicts drive and saturation
// per sample and compares every output transfer in order. Gains and the zero
// band are rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_pid_controller_integral_reset_top;
	import pidir_pkg::*;

	localparam int FRAC_BITS      = FRAC_BITS_DEF;
	localparam int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF;
	localparam longint INTEG_MAX  = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
	localparam longint INTEG_MIN  = -(longint'(1) <<< (INTEGRAL_WIDTH - 1));
	localparam longint DRIVE_MAX  = 64'sd2147483647;
	localparam longint DRIVE_MIN  = -64'sd2147483648;
	localparam int STALL_LIMIT    = 5000;
	localparam int PHASE_SAMPLES  = 130;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] setpoint;
		logic signed [DATA_W-1:0] measured;
	} pid_sample_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      saturated;
	} drive_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata = '0;   // setpoint[15:0], measured[31:16]
	logic [CMD_W-1:0]     s_axis_tuser = '0;   // cmd[1:0]
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [DRIVE_W-1:0]   m_axis_tdata;        // drive[31:0]
	logic                 m_axis_tuser;        // saturated[0]

	pid_controller_integral_reset_top #(
		.FRAC_BITS      (FRAC_BITS),
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// controller mirror
	longint gain_p = 0, gain_i = 0, gain_d = 0, zero_band = longint'(1) << (FRAC_BITS - 1);
	longint integ = 0, last_err = 0;
	bit     started = 1'b0;

	pid_sample_t sample_q[$];
	drive_t      drive_due_q[$];

	int n_queued = 0, n_checked = 0, n_sat = 0, n_isat = 0, n_clears = 0, n_resets = 0;
	int n_phases = 0, mismatches = 0, idle_cycles = 0;
	int burst_left = 0, gap_left = 0, rdy_hold = 0, rdy_pick;
	logic in_took = 1'b0;
	pid_sample_t drv_item;
	drive_t      due;

	function automatic int sgn(longint v);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	function automatic drive_t pid_update(pid_sample_t s);
		longint e, prev, acc, drv;
		bit     sat;
		drive_t r;
		sat = 1'b0;
		if (s.cmd == CMD_RESET || s.cmd == CMD_SPARE) begin
			integ = 0;
			last_err = 0;
			started = 1'b0;
			n_resets++;
			r.drive = '0;
			r.saturated = 1'b0;
			return r;
		end
		e = (s.cmd == CMD_ERROR) ? longint'(s.setpoint)
		                         : longint'(s.setpoint) - longint'(s.measured);
		// first step after reset: derivative zero, no sign-change clear
		prev = started ? last_err : e;
		started = 1'b1;
		integ += e;
		if (integ > INTEG_MAX) begin integ = INTEG_MAX; sat = 1'b1; n_isat++; end
		if (integ < INTEG_MIN) begin integ = INTEG_MIN; sat = 1'b1; n_isat++; end
		acc = gain_p * e + gain_i * integ + gain_d * (e - prev);
		drv = acc >>> FRAC_BITS;
		if (drv > DRIVE_MAX) begin drv = DRIVE_MAX; sat = 1'b1; end
		if (drv < DRIVE_MIN) begin drv = DRIVE_MIN; sat = 1'b1; end
		last_err = e;
		if (s.cmd == CMD_ERROR &&
		    (sgn(e) != sgn(prev) || ((e < 0) ? -e : e) < zero_band)) begin
			integ = 0;
			n_clears++;
		end
		if (sat) n_sat++;
		r.drive = drv[DRIVE_W-1:0];
		r.saturated = sat;
		return r;
	endfunction

	// prediction and checking
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (drive_due_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual drive %0d sat %0b",
				         $time, $signed(m_axis_tdata), m_axis_tuser);
			end else begin
				due = drive_due_q.pop_front();
				n_checked++;
				if (m_axis_tdata !== due.drive || m_axis_tuser !== due.saturated) begin
					mismatches++;
					$display("%0t: result %0d expected drive %0d sat %0b, actual drive %0d sat %0b",
					         $time, n_checked, due.drive, due.saturated,
					         $signed(m_axis_tdata), m_axis_tuser);
				end
			end
		end
		if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P:    gain_p = longint'($signed(cfg_data));
				REG_GAIN_I:    gain_i = longint'($signed(cfg_data));
				REG_GAIN_D:    gain_d = longint'($signed(cfg_data));
				REG_ZERO_BAND: zero_band = longint'(cfg_data);
				default: ;
			endcase
		end
		if (s_axis_tvalid && s_axis_tready)
			drive_due_q.push_back(pid_update({s_axis_tuser, s_axis_tdata[15:0],
			                                  s_axis_tdata[31:16]}));
		in_took <= s_axis_tvalid && s_axis_tready;
	end

	// no transfer on either side for too long ends the run
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (idle_cycles == STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("FAIL pid_controller_integral_reset_top");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// sender in bursts, receiver on its own hold pattern
	always @(negedge clk) begin
		if (!s_axis_tvalid || in_took) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				drv_item = sample_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {drv_item.measured, drv_item.setpoint};
				s_axis_tuser <= drv_item.cmd;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 32);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else
					burst_left <= burst_left - 1;
			end else
				s_axis_tvalid <= 1'b0;
		end
		if (rdy_hold != 0)
			rdy_hold <= rdy_hold - 1;
		else begin
			rdy_pick = $urandom_range(0, 99);
			if (rdy_pick < 50) begin
				m_axis_tready <= 1'b1;
				rdy_hold <= $urandom_range(0, 40);
			end else if (rdy_pick < 85) begin
				m_axis_tready <= 1'b0;
				rdy_hold <= $urandom_range(0, 5);
			end else begin
				m_axis_tready <= 1'b0;
				rdy_hold <= $urandom_range(10, 25);
			end
		end
	end

	function automatic int rand16();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic logic [DATA_W-1:0] clamp16(int v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[DATA_W-1:0];
	endfunction

	task automatic push_sample(logic [CMD_W-1:0] c, int sp, int ms);
		pid_sample_t s;
		s.cmd = c;
		s.setpoint = clamp16(sp);
		s.measured = clamp16(ms);
		sample_q.push_back(s);
		n_queued++;
	endtask

	task automatic write_regs(int kp, int ki, int kd, int zb);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= REG_GAIN_P; cfg_data <= kp[DATA_W-1:0];
		@(negedge clk);
		cfg_index <= REG_GAIN_I; cfg_data <= ki[DATA_W-1:0];
		@(negedge clk);
		cfg_index <= REG_GAIN_D; cfg_data <= kd[DATA_W-1:0];
		@(negedge clk);
		cfg_index <= REG_ZERO_BAND; cfg_data <= zb[DATA_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		n_phases++;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (sample_q.size() != 0 || s_axis_tvalid || drive_due_q.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// one run of samples: tracking loop, windup, near-band chatter or noise
	task automatic queue_segment();
		int kind, len, target, meas, sg, b;
		logic [CMD_W-1:0] c;
		if ($urandom_range(0, 3) == 0)
			push_sample($urandom_range(0, 1) ? CMD_RESET : CMD_SPARE, rand16(), rand16());
		kind = $urandom_range(0, 99);
		c = $urandom_range(0, 1) ? CMD_DIFF : CMD_ERROR;
		if (kind < 45) begin
			len = $urandom_range(4, 40);
			target = rand16();
			meas = rand16();
			repeat (len) begin
				if (c == CMD_DIFF) push_sample(c, target, meas);
				else push_sample(c, target - meas, rand16());
				meas = meas + (target - meas) / 4 + int'($urandom_range(0, 128)) - 64;
			end
		end else if (kind < 60) begin
			// same-sign large error pushes the integral and drive into their limits
			len = $urandom_range(80, 300);
			sg = $urandom_range(0, 1) ? 1 : -1;
			repeat (len) begin
				if (c == CMD_ERROR)
					push_sample(c, sg * int'($urandom_range(1, 32767)), rand16());
				else
					push_sample(c, sg * int'($urandom_range(1, 32767)),
					            -sg * int'($urandom_range(0, 32767)));
			end
		end else if (kind < 80) begin
			len = $urandom_range(5, 30);
			b = int'(zero_band) * 2 + 2;
			if (b > 40000) b = 40000;
			repeat (len)
				push_sample(CMD_ERROR, int'($urandom_range(0, 2 * b)) - b, rand16());
		end else begin
			len = $urandom_range(1, 10);
			repeat (len)
				push_sample(CMD_W'($urandom_range(0, 3)), rand16(), rand16());
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset settings: all gains zero
		push_sample(CMD_ERROR, 32767, 0);
		push_sample(CMD_DIFF, -32768, 32767);
		push_sample(CMD_RESET, 0, 0);
		push_sample(CMD_ERROR, -5, -1);
		wait_drained();

		write_regs(256, 64, -512, 128);
		@(posedge clk);
		push_sample(CMD_ERROR, 32767, 0);         // first step, derivative zero
		push_sample(CMD_ERROR, 32767, -1);
		push_sample(CMD_ERROR, -32768, 21845);    // sign change clears
		push_sample(CMD_ERROR, 0, 0);             // zero sign
		push_sample(CMD_ERROR, 127, 0);           // under the band
		push_sample(CMD_ERROR, 128, 0);           // on the band edge
		push_sample(CMD_ERROR, -129, 0);
		push_sample(CMD_DIFF, 32767, -32768);     // widest positive error
		push_sample(CMD_DIFF, -32768, 32767);     // widest negative error
		push_sample(CMD_DIFF, 0, 0);
		push_sample(CMD_RESET, -1, -1);
		push_sample(CMD_ERROR, 500, 0);           // first step after reset
		push_sample(CMD_SPARE, 1234, -4321);      // unused code acts as reset
		push_sample(CMD_DIFF, 1000, 200);
		push_sample(CMD_DIFF, -1, 0);
		push_sample(CMD_ERROR, -1, 0);
		push_sample(CMD_ERROR, 1, 0);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_regs(32767, 32767, 32767, 65535);
				1: write_regs(-32768, -32768, -32768, 0);
				2, 7: write_regs(rand16() / 64, rand16() / 64, rand16() / 64,
				                 $urandom_range(0, 1024));
				3: write_regs(rand16(), rand16(), rand16(), $urandom_range(0, 65535));
				4: write_regs(256, 0, 0, 128);
				5: write_regs(0, 32767, 0, 256);
				default: write_regs(-32768, 100, 32767, $urandom_range(0, 4096));
			endcase
			@(posedge clk);
			while (sample_q.size() < PHASE_SAMPLES)
				queue_segment();
			wait_drained();
		end

		$display("Ran %0d samples through %0d gain settings, %0d results checked.",
		         n_queued, n_phases + 1, n_checked);
		$display("Saw %0d saturated steps (%0d on the integral), %0d integral clears, %0d state resets.",
		         n_sat, n_isat, n_clears, n_resets);
		if (mismatches == 0)
			$display("PASS pid_controller_integral_reset_top");
		else
			$display("FAIL pid_controller_integral_reset_top");
		$finish;
	end

endmodule
